// ----- hw/rtl/bsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_pkg: shared types and constants of the sweep path generator
// Command and status codes, edge record layout and the request/response
// bundles of the interpolation unit.
// ----------------------------------------------------------------------------
package bsp_pkg;

   // coordinate and arithmetic widths
   localparam int COORD_W       = 32;
   localparam int DIFF_W        = COORD_W + 1;
   localparam int ACC_W         = 2 * DIFF_W;
   localparam int STEP_W        = 31;
   localparam int LINE_W        = 16;
   localparam int PROD_W        = LINE_W + STEP_W;
   localparam int ITER_W        = 7;
   localparam int MAX_EDGES_DEF = 32;
   localparam int ADDR_W        = 4;

   // register map, word index taken from paddr[3:2]
   localparam logic [1:0] REG_START_X = 2'd0;
   localparam logic [1:0] REG_END_X   = 2'd1;
   localparam logic [1:0] REG_STEP    = 2'd2;

   typedef enum logic [1:0] {
      CMD_CLEAR        = 2'd0,
      CMD_APPEND_CEIL  = 2'd1,
      CMD_APPEND_FLOOR = 2'd2,
      CMD_SWEEP        = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_POINT    = 2'd0,
      STAT_FINISHED = 2'd1,
      STAT_NO_HIT   = 2'd2,
      STAT_BAD_STEP = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic signed [COORD_W-1:0] ex;
      logic signed [COORD_W-1:0] ey;
   } edge_type;

   typedef struct packed {
      logic                      start;
      edge_type                  seg;
      logic signed [COORD_W-1:0] x;
   } interp_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [COORD_W-1:0] y;
   } interp_rsp_type;

endpackage
`default_nettype wire

// ----- hw/rtl/boustrophedon_sweep_path.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// boustrophedon_sweep_path: sweep path generator for one cell
// Stores ceiling and floor edge chains and emits the points of one vertical
// sweep line per sweep command, alternating direction.
//
//   channel  ports          direction  carries
//   req      req_*          in         command word and edge vertices
//   rsp      rsp_*          out        path point, status, last flag
//   csr      psel..prdata   in/out     cell start/end x, step size
//
// Clear and append words are taken in the idle state. A sweep word scans both
// edge chains, then interpolates one to three points and emits the kink
// vertices between them; the shared interpolation unit (33 shift-add steps
// and 66 divide steps) computes each point's y. req_ready is high only when
// the sequencer is idle. A stalled rsp holds the sequencer at its next result.
// Reset is synchronous; the edge memories are not cleared.
// ----------------------------------------------------------------------------
module boustrophedon_sweep_path #(
   parameter int MAX_EDGES = bsp_pkg::MAX_EDGES_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // command channel
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [1:0]                   req_cmd,
   input  wire logic signed [31:0]           req_edge_begin_x,
   input  wire logic signed [31:0]           req_edge_begin_y,
   input  wire logic signed [31:0]           req_edge_end_x,
   input  wire logic signed [31:0]           req_edge_end_y,
   // result channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [31:0]                rsp_point_x,
   output logic signed [31:0]                rsp_point_y,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_last,
   // register port
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [bsp_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [31:0]                  pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   localparam int IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CNT_W = $clog2(MAX_EDGES + 1);
   localparam int CW    = bsp_pkg::COORD_W;
   localparam int SW    = bsp_pkg::STEP_W;
   localparam int LW    = bsp_pkg::LINE_W;
   localparam int PW    = bsp_pkg::PROD_W;
   localparam int DW    = bsp_pkg::DIFF_W;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b00000000001,
      ST_CHECK    = 11'b00000000010,
      ST_SCAN_RD  = 11'b00000000100,
      ST_SCAN_CMP = 11'b00000001000,
      ST_EVAL     = 11'b00000010000,
      ST_PT_RD    = 11'b00000100000,
      ST_PT_LOAD  = 11'b00001000000,
      ST_PT_MATH  = 11'b00010000000,
      ST_KINK_RD  = 11'b00100000000,
      ST_KINK_OUT = 11'b01000000000,
      ST_EMIT     = 11'b10000000000
   } state_type;

   // which point of the line is interpolated
   typedef enum logic [2:0] {
      PH_START = 3'b001,
      PH_END   = 3'b010,
      PH_NEXT  = 3'b100
   } phase_type;

   state_type               state_ff, state_in, ret_ff, ret_in;
   phase_type               phase_ff, phase_in;

   logic signed [CW-1:0]    start_x_ff, start_x_in, end_x_ff, end_x_in;
   logic [SW-1:0]           step_ff, step_in;
   logic [CNT_W-1:0]        ceil_cnt_ff, ceil_cnt_in, floor_cnt_ff, floor_cnt_in;
   logic [LW-1:0]           line_ff, line_in;
   logic                    down_ff, down_in;
   bsp_pkg::status_type     run_ff, run_in;

   logic signed [DW-1:0]    w_ff, w_in;
   logic [PW-1:0]           prod_ff, prod_in;
   logic                    final_ff, final_in;
   logic signed [CW-1:0]    x_ff, x_in, nx_ff, nx_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic                    scan_end_ff, scan_end_in;
   logic                    sf_ff, sf_in, ef_ff, ef_in, nf_ff, nf_in;
   logic [IDX_W-1:0]        si_ff, si_in, ei_ff, ei_in, ni_ff, ni_in;
   logic                    up_ff, up_in;

   logic signed [CW-1:0]    res_x_ff, res_x_in, res_y_ff, res_y_in;
   bsp_pkg::status_type     res_st_ff, res_st_in;
   logic                    res_last_ff, res_last_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0]    rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   bsp_pkg::status_type     rsp_st_ff, rsp_st_in;
   logic                    rsp_last_ff, rsp_last_in;

   // memories and interpolation unit
   logic                    wr_ceil, wr_floor;
   logic [IDX_W-1:0]        wr_addr, rd_addr, pidx;
   bsp_pkg::edge_type       wr_data, ceil_rd, floor_rd, rd_seg;
   logic                    rd_ceil;
   bsp_pkg::interp_req_type ireq;
   bsp_pkg::interp_rsp_type irsp;

   // range checks and next sweep x
   logic [PW-1:0]           w_lo, step_hi;
   logic [PW:0]             p1;
   logic                    bad_w, past_end, is_final;
   logic signed [CW-1:0]    lo, hi, xq;
   logic                    hit_x, hit_nx, scan_ceil;
   logic [CNT_W-1:0]        scan_cnt;
   logic                    csr_wr;

   assign w_lo     = PW'(w_ff[CW-1:0]);
   assign step_hi  = {step_ff, LW'(0)};
   assign p1       = {1'b0, prod_ff} + (PW + 1)'(step_ff);
   assign bad_w    = (w_ff <= $signed(DW'(0))) || (step_ff == '0) || (w_lo >= step_hi);
   assign past_end = prod_ff > w_lo;
   assign is_final = p1 > {1'b0, w_lo};

   // edge span test
   assign lo     = ($signed(rd_seg.bx) < $signed(rd_seg.ex)) ? rd_seg.bx : rd_seg.ex;
   assign hi     = ($signed(rd_seg.bx) < $signed(rd_seg.ex)) ? rd_seg.ex : rd_seg.bx;
   assign hit_x  = (x_ff >= lo) && (x_ff <= hi);
   assign hit_nx = (nx_ff >= lo) && (nx_ff <= hi);

   // the start chain is the ceiling when sweeping down
   assign scan_ceil = scan_end_ff ^ down_ff;
   assign scan_cnt  = scan_ceil ? ceil_cnt_ff : floor_cnt_ff;
   assign xq        = (phase_ff == PH_NEXT) ? nx_ff : x_ff;

   always_comb begin
      priority case (phase_ff)
         PH_START: pidx = si_ff;
         PH_END:   pidx = ei_ff;
         default:  pidx = ni_ff;
      endcase
   end

   // read address and chain select
   always_comb begin
      if (state_ff == ST_PT_RD) begin
         rd_addr = pidx;
      end else begin
         rd_addr = k_ff[IDX_W-1:0];
      end
      if (state_ff == ST_SCAN_CMP) begin
         rd_ceil = scan_ceil;
      end else if (state_ff == ST_PT_LOAD && phase_ff == PH_START) begin
         rd_ceil = down_ff;
      end else begin
         rd_ceil = !down_ff;
      end
   end
   assign rd_seg = rd_ceil ? ceil_rd : floor_rd;

   assign wr_data.bx = req_edge_begin_x;
   assign wr_data.by = req_edge_begin_y;
   assign wr_data.ex = req_edge_end_x;
   assign wr_data.ey = req_edge_end_y;
   assign wr_addr    = (req_cmd == bsp_pkg::CMD_APPEND_CEIL) ?
                       ceil_cnt_ff[IDX_W-1:0] : floor_cnt_ff[IDX_W-1:0];

   assign ireq.start = (state_ff == ST_PT_LOAD);
   assign ireq.seg   = rd_seg;
   assign ireq.x     = xq;

   assign csr_wr = psel && penable && pwrite;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      phase_in     = phase_ff;
      start_x_in   = start_x_ff;
      end_x_in     = end_x_ff;
      step_in      = step_ff;
      ceil_cnt_in  = ceil_cnt_ff;
      floor_cnt_in = floor_cnt_ff;
      line_in      = line_ff;
      down_in      = down_ff;
      run_in       = run_ff;
      w_in         = w_ff;
      prod_in      = prod_ff;
      final_in     = final_ff;
      x_in         = x_ff;
      nx_in        = nx_ff;
      k_in         = k_ff;
      scan_end_in  = scan_end_ff;
      sf_in        = sf_ff;
      ef_in        = ef_ff;
      nf_in        = nf_ff;
      si_in        = si_ff;
      ei_in        = ei_ff;
      ni_in        = ni_ff;
      up_in        = up_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_st_in    = res_st_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_last_in  = rsp_last_ff;
      wr_ceil      = 1'b0;
      wr_floor     = 1'b0;

      // register writes
      if (csr_wr) begin
         unique case (paddr[3:2])
            bsp_pkg::REG_START_X: start_x_in = pwdata;
            bsp_pkg::REG_END_X:   end_x_in   = pwdata;
            bsp_pkg::REG_STEP:    step_in    = pwdata[SW-1:0];
            default: ;
         endcase
      end

      // output register drains
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (bsp_pkg::cmd_type'(req_cmd))
                  bsp_pkg::CMD_CLEAR: begin
                     ceil_cnt_in  = '0;
                     floor_cnt_in = '0;
                     line_in      = '0;
                     down_in      = 1'b1;
                     run_in       = bsp_pkg::STAT_POINT;
                  end
                  bsp_pkg::CMD_APPEND_CEIL: begin
                     if (ceil_cnt_ff < CNT_W'(MAX_EDGES)) begin
                        wr_ceil     = 1'b1;
                        ceil_cnt_in = ceil_cnt_ff + 1'b1;
                     end
                  end
                  bsp_pkg::CMD_APPEND_FLOOR: begin
                     if (floor_cnt_ff < CNT_W'(MAX_EDGES)) begin
                        wr_floor     = 1'b1;
                        floor_cnt_in = floor_cnt_ff + 1'b1;
                     end
                  end
                  bsp_pkg::CMD_SWEEP: begin
                     if (run_ff != bsp_pkg::STAT_POINT) begin
                        // sticky status repeats
                        res_x_in    = '0;
                        res_y_in    = '0;
                        res_st_in   = run_ff;
                        res_last_in = 1'b1;
                        ret_in      = ST_IDLE;
                        state_in    = ST_EMIT;
                     end else begin
                        prod_in  = PW'(line_ff) * PW'(step_ff);
                        w_in     = {end_x_ff[CW-1], end_x_ff} -
                                   {start_x_ff[CW-1], start_x_ff};
                        state_in = ST_CHECK;
                     end
                  end
               endcase
            end
         end
         ST_CHECK: begin
            res_x_in    = '0;
            res_y_in    = '0;
            res_last_in = 1'b1;
            if (bad_w) begin
               run_in    = bsp_pkg::STAT_BAD_STEP;
               res_st_in = bsp_pkg::STAT_BAD_STEP;
               ret_in    = ST_IDLE;
               state_in  = ST_EMIT;
            end else if (past_end) begin
               run_in    = bsp_pkg::STAT_FINISHED;
               res_st_in = bsp_pkg::STAT_FINISHED;
               ret_in    = ST_IDLE;
               state_in  = ST_EMIT;
            end else begin
               final_in    = is_final;
               x_in        = start_x_ff + $signed(prod_ff[CW-1:0]);
               nx_in       = start_x_ff + $signed(p1[CW-1:0]);
               k_in        = '0;
               scan_end_in = 1'b0;
               sf_in       = 1'b0;
               ef_in       = 1'b0;
               nf_in       = 1'b0;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (k_ff < scan_cnt) begin
               state_in = ST_SCAN_CMP;
            end else if (!scan_end_ff) begin
               scan_end_in = 1'b1;
               k_in        = '0;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_SCAN_CMP: begin
            // first edge of the chain wins
            if (!scan_end_ff) begin
               if (!sf_ff && hit_x) begin
                  sf_in = 1'b1;
                  si_in = k_ff[IDX_W-1:0];
               end
            end else begin
               if (!ef_ff && hit_x) begin
                  ef_in = 1'b1;
                  ei_in = k_ff[IDX_W-1:0];
               end
               if (!nf_ff && hit_nx) begin
                  nf_in = 1'b1;
                  ni_in = k_ff[IDX_W-1:0];
               end
            end
            k_in     = k_ff + 1'b1;
            state_in = ST_SCAN_RD;
         end
         ST_EVAL: begin
            up_in = ei_ff < ni_ff;
            if (!sf_ff || !ef_ff || (!final_ff && !nf_ff)) begin
               run_in      = bsp_pkg::STAT_NO_HIT;
               res_x_in    = '0;
               res_y_in    = '0;
               res_st_in   = bsp_pkg::STAT_NO_HIT;
               res_last_in = 1'b1;
               ret_in      = ST_IDLE;
               state_in    = ST_EMIT;
            end else begin
               phase_in = (line_ff == '0) ? PH_START : PH_END;
               state_in = ST_PT_RD;
            end
         end
         ST_PT_RD: begin
            state_in = ST_PT_LOAD;
         end
         ST_PT_LOAD: begin
            state_in = ST_PT_MATH;
         end
         ST_PT_MATH: begin
            if (irsp.done) begin
               res_x_in    = xq;
               res_y_in    = irsp.y;
               res_st_in   = bsp_pkg::STAT_POINT;
               res_last_in = (phase_ff == PH_NEXT);
               state_in    = ST_EMIT;
               priority case (phase_ff)
                  PH_START: begin
                     phase_in = PH_END;
                     ret_in   = ST_PT_RD;
                  end
                  PH_END: begin
                     k_in   = CNT_W'(ei_ff);
                     ret_in = ST_KINK_RD;
                  end
                  default: begin
                     line_in = line_ff + 1'b1;
                     down_in = !down_ff;
                     ret_in  = ST_IDLE;
                  end
               endcase
            end
         end
         ST_KINK_RD: begin
            if (final_ff) begin
               // final line closes with the finished status
               run_in      = bsp_pkg::STAT_FINISHED;
               res_x_in    = '0;
               res_y_in    = '0;
               res_st_in   = bsp_pkg::STAT_FINISHED;
               res_last_in = 1'b1;
               ret_in      = ST_IDLE;
               state_in    = ST_EMIT;
            end else if (k_ff[IDX_W-1:0] == ni_ff) begin
               phase_in = PH_NEXT;
               state_in = ST_PT_RD;
            end else begin
               state_in = ST_KINK_OUT;
            end
         end
         ST_KINK_OUT: begin
            // vertex order follows chain direction and active side
            if (up_ff == down_ff) begin
               res_x_in = rd_seg.bx;
               res_y_in = rd_seg.by;
            end else begin
               res_x_in = rd_seg.ex;
               res_y_in = rd_seg.ey;
            end
            res_st_in   = bsp_pkg::STAT_POINT;
            res_last_in = 1'b0;
            k_in        = up_ff ? k_ff + 1'b1 : k_ff - 1'b1;
            ret_in      = ST_KINK_RD;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_st_in    = res_st_ff;
               rsp_last_in  = res_last_ff;
               state_in     = ret_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         phase_ff     <= PH_START;
         start_x_ff   <= '0;
         end_x_ff     <= '0;
         step_ff      <= SW'(65536);
         ceil_cnt_ff  <= '0;
         floor_cnt_ff <= '0;
         line_ff      <= '0;
         down_ff      <= 1'b1;
         run_ff       <= bsp_pkg::STAT_POINT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         phase_ff     <= phase_in;
         start_x_ff   <= start_x_in;
         end_x_ff     <= end_x_in;
         step_ff      <= step_in;
         ceil_cnt_ff  <= ceil_cnt_in;
         floor_cnt_ff <= floor_cnt_in;
         line_ff      <= line_in;
         down_ff      <= down_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      prod_ff     <= prod_in;
      final_ff    <= final_in;
      x_ff        <= x_in;
      nx_ff       <= nx_in;
      k_ff        <= k_in;
      scan_end_ff <= scan_end_in;
      sf_ff       <= sf_in;
      ef_ff       <= ef_in;
      nf_ff       <= nf_in;
      si_ff       <= si_in;
      ei_ff       <= ei_in;
      ni_ff       <= ni_in;
      up_ff       <= up_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_st_ff   <= res_st_in;
      res_last_ff <= res_last_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
   end

   bsp_edge_store #(.DEPTH(MAX_EDGES)) u_ceil (
      .clock   (clock),
      .wr_en   (wr_ceil),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ceil_rd)
   );

   bsp_edge_store #(.DEPTH(MAX_EDGES)) u_floor (
      .clock   (clock),
      .wr_en   (wr_floor),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (floor_rd)
   );

   bsp_interp u_interp (
      .clock (clock),
      .reset (reset),
      .req   (ireq),
      .rsp   (irsp)
   );

   // register readback
   always_comb begin
      unique case (paddr[3:2])
         bsp_pkg::REG_START_X: prdata = start_x_ff;
         bsp_pkg::REG_END_X:   prdata = end_x_ff;
         bsp_pkg::REG_STEP:    prdata = {1'b0, step_ff};
         default:              prdata = '0;
      endcase
   end

   assign pready      = 1'b1;
   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;
   assign rsp_status  = rsp_st_ff;
   assign rsp_last    = rsp_last_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/bsp_edge_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_edge_store: edge chain memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsp_edge_store #(
   parameter  int DEPTH = bsp_pkg::MAX_EDGES_DEF,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_addr,
   input  wire bsp_pkg::edge_type wr_data,
   input  wire logic [IDX_W-1:0]  rd_addr,
   output bsp_pkg::edge_type      rd_data
);

   bsp_pkg::edge_type mem [DEPTH];
   bsp_pkg::edge_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/bsp_interp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_interp: iterative edge interpolation unit
// y = by + round(|px*dy| / |dx|) with sign applied afterwards; shift-add
// multiply then restoring divide, one step per cycle.
// ----------------------------------------------------------------------------
module bsp_interp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bsp_pkg::interp_req_type req,
   output bsp_pkg::interp_rsp_type      rsp
);

   localparam int DW = bsp_pkg::DIFF_W;
   localparam int AW = bsp_pkg::ACC_W;
   localparam int CW = bsp_pkg::COORD_W;
   localparam int IW = bsp_pkg::ITER_W;

   typedef enum logic [6:0] {
      I_IDLE = 7'b0000001,
      I_ABS  = 7'b0000010,
      I_MUL  = 7'b0000100,
      I_ADD  = 7'b0001000,
      I_DIV  = 7'b0010000,
      I_FIN  = 7'b0100000,
      I_DONE = 7'b1000000
   } istate_type;

   istate_type            st_ff, st_in;
   logic signed [DW-1:0]  dx_ff, dx_in, dy_ff, dy_in, px_ff, px_in;
   logic signed [CW-1:0]  by_ff, by_in, y_ff, y_in;
   logic [DW-1:0]         mdx_ff, mdx_in, mdy_ff, mdy_in, mpx_ff, mpx_in;
   logic [AW-1:0]         acc_ff, acc_in;
   logic [DW-1:0]         rem_ff, rem_in;
   logic [IW-1:0]         cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [DW:0]           trial;
   logic                  fits;

   // one restoring-divide step
   assign trial = {rem_ff, acc_ff[AW-1]};
   assign fits  = trial >= {1'b0, mdx_ff};

   always_comb begin
      st_in  = st_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      px_in  = px_ff;
      by_in  = by_ff;
      y_in   = y_ff;
      mdx_in = mdx_ff;
      mdy_in = mdy_ff;
      mpx_in = mpx_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      unique case (st_ff)
         I_IDLE: begin
            if (req.start) begin
               dx_in = {req.seg.ex[CW-1], req.seg.ex} - {req.seg.bx[CW-1], req.seg.bx};
               dy_in = {req.seg.ey[CW-1], req.seg.ey} - {req.seg.by[CW-1], req.seg.by};
               px_in = {req.x[CW-1], req.x} - {req.seg.bx[CW-1], req.seg.bx};
               by_in = req.seg.by;
               st_in = I_ABS;
            end
         end
         I_ABS: begin
            // vertical edge, flat edge or x on the begin vertex: y is by
            if (dx_ff == '0 || dy_ff == '0 || px_ff == '0) begin
               y_in  = by_ff;
               st_in = I_DONE;
            end else begin
               neg_in = dx_ff[DW-1] ^ dy_ff[DW-1] ^ px_ff[DW-1];
               mdx_in = dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
               mdy_in = dy_ff[DW-1] ? DW'(-dy_ff) : DW'(dy_ff);
               mpx_in = px_ff[DW-1] ? DW'(-px_ff) : DW'(px_ff);
               acc_in = '0;
               cnt_in = '0;
               st_in  = I_MUL;
            end
         end
         I_MUL: begin
            acc_in = {acc_ff[AW-2:0], 1'b0} + (mdy_ff[DW-1] ? AW'(mpx_ff) : AW'(0));
            mdy_in = {mdy_ff[DW-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IW'(DW - 1)) begin
               st_in = I_ADD;
            end
         end
         I_ADD: begin
            // rounding term, halves away from zero
            acc_in = acc_ff + AW'(mdx_ff >> 1);
            rem_in = '0;
            cnt_in = '0;
            st_in  = I_DIV;
         end
         I_DIV: begin
            rem_in = fits ? DW'(trial - {1'b0, mdx_ff}) : trial[DW-1:0];
            acc_in = {acc_ff[AW-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IW'(AW - 1)) begin
               st_in = I_FIN;
            end
         end
         I_FIN: begin
            y_in  = neg_ff ? by_ff - $signed(acc_ff[CW-1:0])
                           : by_ff + $signed(acc_ff[CW-1:0]);
            st_in = I_DONE;
         end
         I_DONE: begin
            st_in = I_IDLE;
         end
         default: begin
            st_in = I_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= I_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      px_ff  <= px_in;
      by_ff  <= by_in;
      y_ff   <= y_in;
      mdx_ff <= mdx_in;
      mdy_ff <= mdy_in;
      mpx_ff <= mpx_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign rsp.done = (st_ff == I_DONE);
   assign rsp.y    = y_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/bsp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_checker: port-level checks of the sweep path generator
// Watches the result channel and req_ready; bound to the top level.
// ----------------------------------------------------------------------------
module bsp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_point_x,
   input wire logic [31:0] rsp_point_y,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_last
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_x) &&
      $stable(rsp_point_y) && $stable(rsp_status) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // status words close the command
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bsp_pkg::STAT_POINT |-> rsp_last)
      else $error("status word without last");

   // status words carry a zero point
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bsp_pkg::STAT_POINT |->
      rsp_point_x == '0 && rsp_point_y == '0)
      else $error("status word with nonzero point");

   // mid-line results mean the sweep is still running
   a_busy_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("command accepted before line finished");

   // reset leaves an idle block with no result
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind boustrophedon_sweep_path bsp_checker u_bsp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_point_x (rsp_point_x),
   .rsp_point_y (rsp_point_y),
   .rsp_status  (rsp_status),
   .rsp_last    (rsp_last)
);
`default_nettype wire
